// ===== sv/s2c_pkg.sv =====
// s2c_pkg: shared constants, types and helper functions for the spherical to
// cartesian converter; used by every module of the block, depends on nothing
`default_nettype none

package s2c_pkg;

  localparam int TRIG_STAGES_DEF = 20;

  localparam int RAD_W    = 30;   // sphere radius register
  localparam int ANG_W    = 25;   // angle as carried into the angle mapper
  localparam int LAT_W    = 24;
  localparam int HGT_W    = 31;
  localparam int MAG_W    = 23;   // |angle| after folding, at most 90 deg
  localparam int THETA_W  = 32;   // Q2.30 radians
  localparam int CORDIC_W = 34;
  localparam int R_W      = 32;   // radius plus height
  localparam int UNIT_W   = 32;   // clamped sine or cosine
  localparam int OUT_W    = 32;
  localparam int ANG_LAT  = 4;    // register stages in the angle mapper
  localparam int SCALE_LAT = 5;   // register stages in the scaler

  localparam logic [RAD_W-1:0] RADIUS_RESET = 30'd419436954;

  localparam longint PI4_Q30  = 843314857;
  localparam longint DEG45    = 2949120;
  localparam longint GAIN_INV = 652032874;

  // floor(2^24 * pi/4 / 45 deg), reciprocal estimate for the radian conversion
  localparam logic [32:0] RECIP = 33'((64'(PI4_Q30) << 24) / 64'(DEG45));

  typedef struct packed {
    logic lon;
    logic lat;
  } fold_t;

  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd843314856;
      5'd1:  v = 32'd497837829;
      5'd2:  v = 32'd263043836;
      5'd3:  v = 32'd133525158;
      5'd4:  v = 32'd67021686;
      5'd5:  v = 32'd33543515;
      5'd6:  v = 32'd16775850;
      5'd7:  v = 32'd8388437;
      5'd8:  v = 32'd4194282;
      5'd9:  v = 32'd2097149;
      5'd10: v = 32'd1048575;
      5'd11: v = 32'd524287;
      5'd12: v = 32'd262143;
      5'd13: v = 32'd131071;
      5'd14: v = 32'd65535;
      5'd15: v = 32'd32767;
      5'd16: v = 32'd16383;
      5'd17: v = 32'd8191;
      5'd18: v = 32'd4095;
      5'd19: v = 32'd2047;
      5'd20: v = 32'd1023;
      5'd21: v = 32'd511;
      5'd22: v = 32'd255;
      5'd23: v = 32'd127;
      5'd24: v = 32'd63;
      5'd25: v = 32'd31;
      5'd26: v = 32'd15;
      5'd27: v = 32'd7;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // clamp to [-2^30, 2^30]
  function automatic logic signed [UNIT_W-1:0] clamp_unit(
      input logic signed [CORDIC_W-1:0] v);
    logic signed [UNIT_W-1:0] res;
    if (v > 34'sd1073741824) begin
      res = 32'sd1073741824;
    end else if (v < -34'sd1073741824) begin
      res = -32'sd1073741824;
    end else begin
      res = v[UNIT_W-1:0];
    end
    return res;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat32(input logic signed [39:0] v);
    logic signed [OUT_W-1:0] res;
    if (v > 40'sd2147483647) begin
      res = 32'sh7fffffff;
    end else if (v < -40'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = v[OUT_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== sv/s2c_angle_map.sv =====
// s2c_angle_map: wraps and folds one angle, converts it to Q2.30 radians
// depends on s2c_pkg
`default_nettype none

module s2c_angle_map (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  input  wire logic signed [s2c_pkg::ANG_W-1:0]      in_angle,
  output logic                                       out_valid,
  output logic signed [s2c_pkg::THETA_W-1:0]         out_theta,
  output logic                                       out_neg
);

  localparam logic signed [25:0] D90  = 26'sd5898240;
  localparam logic signed [25:0] D180 = 26'sd11796480;
  localparam logic signed [25:0] D360 = 26'sd23592960;
  localparam logic [52:0] PI4 = 53'(s2c_pkg::PI4_Q30);
  localparam logic [53:0] DEG45_W = 54'(s2c_pkg::DEG45);
  localparam logic [53:0] HALF45  = 54'(s2c_pkg::DEG45 / 2);

  // stage 1: wrap and fold
  logic signed [25:0] a_wrap, a_fold, a_mag;
  logic               fold_nxt;
  logic               v1_r, sgn1_r, neg1_r;
  logic [s2c_pkg::MAG_W-1:0] mag1_r;

  always_comb begin
    a_wrap = 26'(in_angle);
    if (a_wrap > D180) begin
      a_wrap = a_wrap - D360;
    end
    if (a_wrap < -D180) begin
      a_wrap = a_wrap + D360;
    end
    fold_nxt = 1'b0;
    a_fold   = a_wrap;
    if (a_fold > D90) begin
      a_fold   = a_fold - D180;
      fold_nxt = 1'b1;
    end else if (a_fold < -D90) begin
      a_fold   = a_fold + D180;
      fold_nxt = 1'b1;
    end
    a_mag = a_fold[25] ? -a_fold : a_fold;
  end

  // stage 2: exact numerator and reciprocal estimate
  logic        v2_r, sgn2_r, neg2_r;
  logic [52:0] pn2_r;
  logic [55:0] pf2_r;

  // stage 3: quotient estimate and its multiple of 45
  logic [55:0] qsum;
  logic        v3_r, sgn3_r, neg3_r;
  logic [31:0] q3_r;
  logic [53:0] n3_r;
  logic [37:0] qm3_r;

  assign qsum = pf2_r + 56'd8388608;

  // stage 4: one-step correction, sign
  logic [53:0] diff;
  logic [31:0] q_fix;
  logic        v4_r, neg4_r;
  logic signed [s2c_pkg::THETA_W-1:0] theta4_r;

  always_comb begin
    diff  = n3_r - {qm3_r, 16'd0};
    q_fix = (diff >= DEG45_W) ? q3_r + 32'd1 : q3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    mag1_r   <= a_mag[s2c_pkg::MAG_W-1:0];
    sgn1_r   <= a_fold[25];
    neg1_r   <= fold_nxt;
    pn2_r    <= 53'(mag1_r) * PI4;
    pf2_r    <= 56'(mag1_r) * 56'(s2c_pkg::RECIP);
    sgn2_r   <= sgn1_r;
    neg2_r   <= neg1_r;
    q3_r     <= qsum[55:24];
    n3_r     <= 54'(pn2_r) + HALF45;
    qm3_r    <= 38'(qsum[55:24]) * 38'd45;
    sgn3_r   <= sgn2_r;
    neg3_r   <= neg2_r;
    theta4_r <= sgn3_r ? -$signed(q_fix) : $signed(q_fix);
    neg4_r   <= neg3_r;
  end

  assign out_valid = v4_r;
  assign out_theta = theta4_r;
  assign out_neg   = neg4_r;

endmodule

`default_nettype wire

// ===== sv/s2c_cordic.sv =====
// s2c_cordic: rotation-mode cordic, one iteration per register stage
// depends on s2c_pkg
`default_nettype none

module s2c_cordic #(
  parameter int STAGES = s2c_pkg::TRIG_STAGES_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  input  wire logic signed [s2c_pkg::THETA_W-1:0]    in_theta,
  output logic                                       out_valid,
  output logic signed [s2c_pkg::CORDIC_W-1:0]        out_cos,
  output logic signed [s2c_pkg::CORDIC_W-1:0]        out_sin
);

  localparam int CW = s2c_pkg::CORDIC_W;
  localparam logic signed [CW-1:0] GAIN = CW'(s2c_pkg::GAIN_INV);

  logic signed [CW-1:0] x_r [STAGES];
  logic signed [CW-1:0] y_r [STAGES];
  logic signed [CW-1:0] z_r [STAGES];
  logic [STAGES-1:0]    v_r;

  for (genvar i = 0; i < STAGES; i++) begin : g_st
    logic signed [CW-1:0] xi, yi, zi, dx, dy, at;
    logic                 vi;

    if (i == 0) begin : g_first
      assign xi = GAIN;
      assign yi = '0;
      assign zi = CW'(in_theta);
      assign vi = in_valid;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
      assign vi = v_r[i-1];
    end

    assign dx = yi >>> i;
    assign dy = xi >>> i;
    assign at = $signed({2'b00, s2c_pkg::atan_q30(5'(i))});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (!zi[CW-1]) begin
        x_r[i] <= xi - dx;
        y_r[i] <= yi + dy;
        z_r[i] <= zi - at;
      end else begin
        x_r[i] <= xi + dx;
        y_r[i] <= yi - dy;
        z_r[i] <= zi + at;
      end
    end
  end

  assign out_valid = v_r[STAGES-1];
  assign out_cos   = x_r[STAGES-1];
  assign out_sin   = y_r[STAGES-1];

endmodule

`default_nettype wire

// ===== sv/s2c_scale.sv =====
// s2c_scale: clamps sine and cosine, scales by the radius, rounds and saturates
// depends on s2c_pkg
`default_nettype none

module s2c_scale (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  input  wire s2c_pkg::fold_t                        in_fold,
  input  wire logic signed [s2c_pkg::R_W-1:0]        in_radius,
  input  wire logic signed [s2c_pkg::CORDIC_W-1:0]   in_cos_lon,
  input  wire logic signed [s2c_pkg::CORDIC_W-1:0]   in_sin_lon,
  input  wire logic signed [s2c_pkg::CORDIC_W-1:0]   in_cos_lat,
  input  wire logic signed [s2c_pkg::CORDIC_W-1:0]   in_sin_lat,
  output logic                                       out_valid,
  output logic signed [s2c_pkg::OUT_W-1:0]           out_x,
  output logic signed [s2c_pkg::OUT_W-1:0]           out_y,
  output logic signed [s2c_pkg::OUT_W-1:0]           out_z
);

  localparam int UW = s2c_pkg::UNIT_W;

  logic signed [UW-1:0] clon_c, slon_c, clat_c, slat_c;

  always_comb begin
    clon_c = s2c_pkg::clamp_unit(in_cos_lon);
    slon_c = s2c_pkg::clamp_unit(in_sin_lon);
    clat_c = s2c_pkg::clamp_unit(in_cos_lat);
    slat_c = s2c_pkg::clamp_unit(in_sin_lat);
  end

  logic [s2c_pkg::SCALE_LAT-1:0] v_r;

  // stage 1
  logic signed [UW-1:0] clon1_r, nslon1_r, clat1_r, slat1_r;
  logic signed [s2c_pkg::R_W-1:0] r1_r;
  // stage 2
  logic signed [63:0]   pt2_r, pz2_r;
  logic signed [UW-1:0] clon2_r, nslon2_r;
  // stage 3
  logic signed [63:0]   tsum, zsum;
  logic signed [33:0]   t3_r;
  logic signed [UW-1:0] clon3_r, nslon3_r;
  logic signed [s2c_pkg::OUT_W-1:0] z3_r, z4_r;
  // stage 4
  logic signed [65:0]   px4_r, py4_r;
  logic signed [65:0]   xsum, ysum;
  // stage 5
  logic signed [s2c_pkg::OUT_W-1:0] x5_r, y5_r, z5_r;

  assign tsum = pt2_r + 64'sd536870912;
  assign zsum = pz2_r + 64'sd536870912;
  assign xsum = px4_r + 66'sd536870912;
  assign ysum = py4_r + 66'sd536870912;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[s2c_pkg::SCALE_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    clon1_r  <= in_fold.lon ? -clon_c : clon_c;
    nslon1_r <= in_fold.lon ? slon_c : -slon_c;
    clat1_r  <= in_fold.lat ? -clat_c : clat_c;
    slat1_r  <= in_fold.lat ? -slat_c : slat_c;
    r1_r     <= in_radius;

    pt2_r    <= 64'(r1_r) * 64'(clat1_r);
    pz2_r    <= 64'(r1_r) * 64'(slat1_r);
    clon2_r  <= clon1_r;
    nslon2_r <= nslon1_r;

    t3_r     <= $signed(tsum[63:30]);
    z3_r     <= s2c_pkg::sat32(40'($signed(zsum[63:30])));
    clon3_r  <= clon2_r;
    nslon3_r <= nslon2_r;

    px4_r    <= 66'(t3_r) * 66'(nslon3_r);
    py4_r    <= 66'(t3_r) * 66'(clon3_r);
    z4_r     <= z3_r;

    x5_r     <= s2c_pkg::sat32(40'($signed(xsum[65:30])));
    y5_r     <= s2c_pkg::sat32(40'($signed(ysum[65:30])));
    z5_r     <= z4_r;
  end

  assign out_valid = v_r[s2c_pkg::SCALE_LAT-1];
  assign out_x     = x5_r;
  assign out_y     = y5_r;
  assign out_z     = z5_r;

endmodule

`default_nettype wire

// ===== sv/spherical_to_cartesian_convert_top.sv =====
// spherical_to_cartesian_convert_top: vertex converter top level
// depends on s2c_pkg, s2c_angle_map, s2c_cordic, s2c_scale
`default_nettype none

// Converts one vertex (longitude, latitude, height) per clock into x, y, z in
// signed Q16.16 km on a sphere of radius cfg radius plus height. A beat is
// taken whenever start is high; busy never rises, so a new vertex can enter
// every cycle. Each result appears for exactly one cycle with out_valid high,
// after its start beat has passed through four stages of angle wrap and
// radian conversion, one stage per cordic iteration, then five stages of
// clamp, two multiply rounds, rounding and saturation.
// The receiver cannot stall the pipeline and must take every result as it
// comes. The radius register is written with cfg_wr_en and takes effect for
// vertices started afterwards; it should only change while no vertex is in
// flight. No clearing pass or warm-up is needed after reset.
module spherical_to_cartesian_convert_top #(
  parameter int TRIG_STAGES = s2c_pkg::TRIG_STAGES_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic signed [s2c_pkg::ANG_W-1:0]      in_longitude,
  input  wire logic signed [s2c_pkg::LAT_W-1:0]      in_latitude,
  input  wire logic signed [s2c_pkg::HGT_W-1:0]      in_height,
  input  wire logic                                  cfg_wr_en,
  input  wire logic [s2c_pkg::RAD_W-1:0]             cfg_wr_data,
  output logic                                       out_valid,
  output logic signed [s2c_pkg::OUT_W-1:0]           out_coord_x,
  output logic signed [s2c_pkg::OUT_W-1:0]           out_coord_y,
  output logic signed [s2c_pkg::OUT_W-1:0]           out_coord_z
);

  localparam int CW   = s2c_pkg::CORDIC_W;
  localparam int RDLY = s2c_pkg::ANG_LAT + TRIG_STAGES;

  // radius register
  logic [s2c_pkg::RAD_W-1:0] radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= s2c_pkg::RADIUS_RESET;
    end else if (cfg_wr_en) begin
      radius_r <= cfg_wr_data;
    end
  end

  // pipeline never stalls
  logic accept;
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // total radius, carried alongside the angle path
  logic signed [s2c_pkg::R_W-1:0] r_nxt;
  logic signed [s2c_pkg::R_W-1:0] r_dly_r [RDLY];

  assign r_nxt = $signed({2'b00, radius_r}) + s2c_pkg::R_W'(in_height);

  always_ff @(posedge clk) begin
    r_dly_r[0] <= r_nxt;
    for (int i = 1; i < RDLY; i++) begin
      r_dly_r[i] <= r_dly_r[i-1];
    end
  end

  // angle mapping for both angles
  logic                                  lon_v, lat_v, lon_neg, lat_neg;
  logic signed [s2c_pkg::THETA_W-1:0]    lon_theta, lat_theta;

  s2c_angle_map u_lon_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_angle  (in_longitude),
    .out_valid (lon_v),
    .out_theta (lon_theta),
    .out_neg   (lon_neg)
  );

  s2c_angle_map u_lat_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_angle  (s2c_pkg::ANG_W'(in_latitude)),
    .out_valid (lat_v),
    .out_theta (lat_theta),
    .out_neg   (lat_neg)
  );

  // quadrant fold flags wait out the cordic
  s2c_pkg::fold_t fold_dly_r [TRIG_STAGES];

  always_ff @(posedge clk) begin
    fold_dly_r[0] <= '{lon: lon_neg, lat: lat_neg};
    for (int i = 1; i < TRIG_STAGES; i++) begin
      fold_dly_r[i] <= fold_dly_r[i-1];
    end
  end

  // sine and cosine
  logic                 lon_cv, lat_cv;
  logic signed [CW-1:0] cos_lon, sin_lon, cos_lat, sin_lat;

  s2c_cordic #(.STAGES(TRIG_STAGES)) u_lon_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (lon_v),
    .in_theta  (lon_theta),
    .out_valid (lon_cv),
    .out_cos   (cos_lon),
    .out_sin   (sin_lon)
  );

  s2c_cordic #(.STAGES(TRIG_STAGES)) u_lat_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (lat_v),
    .in_theta  (lat_theta),
    .out_valid (lat_cv),
    .out_cos   (cos_lat),
    .out_sin   (sin_lat)
  );

  // scale, round and saturate
  s2c_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (lon_cv & lat_cv),
    .in_fold    (fold_dly_r[TRIG_STAGES-1]),
    .in_radius  (r_dly_r[RDLY-1]),
    .in_cos_lon (cos_lon),
    .in_sin_lon (sin_lon),
    .in_cos_lat (cos_lat),
    .in_sin_lat (sin_lat),
    .out_valid  (out_valid),
    .out_x      (out_coord_x),
    .out_y      (out_coord_y),
    .out_z      (out_coord_z)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking testbench for spherical_to_cartesian_convert_top
// depends on s2c_pkg and the converter rtl; predicts x, y, z for each vertex beat
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STAGES = s2c_pkg::TRIG_STAGES_DEF;
  localparam int LATENCY = 9 + STAGES;

  localparam longint DEG90  = 5898240;
  localparam longint DEG180 = 11796480;
  localparam longint DEG360 = 23592960;
  localparam longint Q30    = 64'sd1 << 30;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [s2c_pkg::ANG_W-1:0] in_longitude = '0;
  logic signed [s2c_pkg::LAT_W-1:0] in_latitude = '0;
  logic signed [s2c_pkg::HGT_W-1:0] in_height = '0;
  logic cfg_wr_en = 1'b0;
  logic [s2c_pkg::RAD_W-1:0] cfg_wr_data = '0;
  logic out_valid;
  logic signed [s2c_pkg::OUT_W-1:0] out_coord_x, out_coord_y, out_coord_z;

  spherical_to_cartesian_convert_top #(.TRIG_STAGES(STAGES)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_longitude(in_longitude), .in_latitude(in_latitude), .in_height(in_height),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .out_valid(out_valid), .out_coord_x(out_coord_x), .out_coord_y(out_coord_y),
    .out_coord_z(out_coord_z)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  typedef struct {
    logic signed [s2c_pkg::OUT_W-1:0] x;
    logic signed [s2c_pkg::OUT_W-1:0] y;
    logic signed [s2c_pkg::OUT_W-1:0] z;
  } coord_t;

  typedef struct {
    longint lon;
    longint lat;
    longint hgt;
    bit     known;   // expected coords typed in below
    coord_t want;
  } vertex_row_t;

  coord_t pending_coords[$];
  logic [s2c_pkg::RAD_W-1:0] radius_q16;
  int fail_count = 0;
  bit idle_free = 1'b0;

  // floor shift for signed 64-bit values
  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_q30(longint v);
    return (v + (64'sd1 << 29)) >>> 30;
  endfunction

  function automatic logic signed [s2c_pkg::OUT_W-1:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // cordic sine and cosine, angle in 1/65536 degree
  task automatic cordic_sincos(input longint ang, output longint sn, output longint cs);
    bit flip;
    longint mag, th, cx, cy, cz, dx, dy;
    longint atan_tab[32];
    flip = 1'b0;
    atan_tab = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
                 131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
                 127, 63, 31, 15, 7, 3, 1, 0, 0};
    if (ang > DEG180) ang -= DEG360;
    if (ang < -DEG180) ang += DEG360;
    if (ang > DEG90) begin
      ang -= DEG180; flip = 1'b1;
    end else if (ang < -DEG90) begin
      ang += DEG180; flip = 1'b1;
    end
    mag = ang < 0 ? -ang : ang;
    th = (mag * 843314857 + 1474560) / 2949120;
    if (ang < 0) th = -th;
    cx = 652032874; cy = 0; cz = th;
    for (int i = 0; i < STAGES; i++) begin
      dx = shr_floor(cy, i);
      dy = shr_floor(cx, i);
      if (cz >= 0) begin
        cx -= dx; cy += dy; cz -= atan_tab[i];
      end else begin
        cx += dx; cy -= dy; cz += atan_tab[i];
      end
    end
    if (cx > Q30) cx = Q30;
    if (cx < -Q30) cx = -Q30;
    if (cy > Q30) cy = Q30;
    if (cy < -Q30) cy = -Q30;
    if (flip) begin
      cx = -cx; cy = -cy;
    end
    sn = cy; cs = cx;
  endtask

  task automatic project_vertex(input longint lon, input longint lat, input longint hgt,
                                output coord_t c);
    longint r, slon, clon, slat, clat, t;
    r = longint'(radius_q16) + hgt;
    cordic_sincos(lon, slon, clon);
    cordic_sincos(lat, slat, clat);
    t = round_q30(r * clat);
    c.x = clip32(round_q30(t * -slon));
    c.y = clip32(round_q30(t * clon));
    c.z = clip32(round_q30(r * slat));
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // result checker, one beat per out_valid cycle
  always @(posedge clk) begin
    coord_t e;
    if (rst_n && out_valid) begin
      if (pending_coords.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        e = pending_coords.pop_front();
        if (out_coord_x !== e.x) report_mismatch("coord_x", out_coord_x, e.x);
        if (out_coord_y !== e.y) report_mismatch("coord_y", out_coord_y, e.y);
        if (out_coord_z !== e.z) report_mismatch("coord_z", out_coord_z, e.z);
      end
    end
  end

  // random burst of idle cycles on the input side
  task automatic maybe_idle();
    int n;
    if (!idle_free && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 18);
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // drive one vertex beat; start stays high into the next beat if no idle follows
  task automatic send_vertex(input longint lon, input longint lat, input longint hgt,
                             input bit known, input coord_t want);
    coord_t c;
    maybe_idle();
    in_longitude <= lon[s2c_pkg::ANG_W-1:0];
    in_latitude  <= lat[s2c_pkg::LAT_W-1:0];
    in_height    <= hgt[s2c_pkg::HGT_W-1:0];
    start <= 1'b1;
    project_vertex(lon, lat, hgt, c);
    if (known) begin
      if (c.x != want.x || c.y != want.y || c.z != want.z)
        report_mismatch("table row", 0, 1);
      c = want;
    end
    do @(posedge clk); while (busy);
    pending_coords.push_back(c);
    @(negedge clk);
  endtask

  // wait for the pipeline to drain, then write the radius
  task automatic set_radius(input logic [s2c_pkg::RAD_W-1:0] r);
    start <= 1'b0;
    while (pending_coords.size() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
    cfg_wr_data <= r;
    cfg_wr_en <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    radius_q16 = r;
  endtask

  task automatic random_vertex();
    longint lon, lat, hgt;
    coord_t none;
    case ($urandom_range(0, 9))
      0: begin  // raw bit patterns, covers wrapping and every bit
        lon = longint'($signed(s2c_pkg::ANG_W'($urandom)));
        lat = longint'($signed(s2c_pkg::LAT_W'($urandom)));
        hgt = longint'($signed(s2c_pkg::HGT_W'($urandom)));
      end
      1: begin  // near quadrant edges
        lon = DEG90 * $urandom_range(0, 4) - DEG180 + $urandom_range(0, 6) - 3;
        lat = DEG90 * $urandom_range(0, 2) - DEG90 + $urandom_range(0, 6) - 3;
        hgt = longint'($urandom_range(0, 2000)) - 1000;
      end
      default: begin
        lon = longint'($urandom_range(0, 2 * DEG180)) - DEG180;
        lat = longint'($urandom_range(0, 2 * DEG90)) - DEG90;
        hgt = longint'($urandom_range(0, 720896000)) - 65536000;
      end
    endcase
    send_vertex(lon, lat, hgt, 1'b0, none);
  endtask

  vertex_row_t vertex_table[$];

  initial begin
    coord_t none;
    coord_t w;
    none = '{0, 0, 0};
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    radius_q16 = s2c_pkg::RADIUS_RESET;
    @(negedge clk);

    // directed table at the reset radius
    w = '{0, 0, 0};
    // zero radius total: every output exactly zero
    vertex_table.push_back('{0, 0, -longint'(s2c_pkg::RADIUS_RESET), 1, w});
    vertex_table.push_back('{5898240, 0, -longint'(s2c_pkg::RADIUS_RESET), 1, w});
    vertex_table.push_back('{0, 0, 0, 0, none});
    vertex_table.push_back('{DEG180, DEG90, 655360000, 0, none});
    vertex_table.push_back('{-DEG180, -DEG90, -65536000, 0, none});
    vertex_table.push_back('{DEG90, 0, 0, 0, none});
    vertex_table.push_back('{-DEG90, 0, 0, 0, none});
    vertex_table.push_back('{DEG90 + 1, DEG90 + 1, 0, 0, none});
    // latitude past the pole
    vertex_table.push_back('{1000, 8388607, 0, 0, none});
    vertex_table.push_back('{1000, -8388608, 0, 0, none});
    // longitude wrap past 180 degrees, field extremes
    vertex_table.push_back('{16777215, 0, 0, 0, none});
    vertex_table.push_back('{-16777216, 0, 0, 0, none});
    vertex_table.push_back('{DEG180 + 1, 0, 0, 0, none});
    // height extremes including negative total radius
    vertex_table.push_back('{3000000, 2000000, 1073741823, 0, none});
    vertex_table.push_back('{3000000, 2000000, -1073741824, 0, none});
    foreach (vertex_table[i])
      send_vertex(vertex_table[i].lon, vertex_table[i].lat, vertex_table[i].hgt,
                  vertex_table[i].known, vertex_table[i].want);

    // phases over several radius settings, extremes among them
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_radius('0);
        1: set_radius('1);
        2: set_radius(s2c_pkg::RAD_W'($urandom));
        3: set_radius(s2c_pkg::RAD_W'($urandom));
        default: set_radius(s2c_pkg::RADIUS_RESET);
      endcase
      if (ph == 4) idle_free = 1'b1;
      repeat (ph == 4 ? 330 : 255) random_vertex();
    end
    start <= 1'b0;

    while (pending_coords.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // watchdog
  initial begin
    #4ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/s2c_pkg.sv
sv/s2c_angle_map.sv
sv/s2c_cordic.sv
sv/s2c_scale.sv
sv/spherical_to_cartesian_convert_top.sv
tb/sv/tb_top.sv
